// ----- design/apcnl_pkg.sv -----
`default_nettype none

package apcnl_pkg;

   // Store geometry and coordinate format
   localparam int MAX_POINTS  = 32;
   localparam int COORD_WIDTH = 24;
   localparam int IN_WIDTH    = 24;
   localparam int IDX_WIDTH   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_WIDTH   = $clog2(MAX_POINTS + 1);
   localparam int OUT_IDX_WIDTH = 5;

   // Distance arithmetic widths
   localparam int SQ_WIDTH   = 2 * COORD_WIDTH;
   localparam int D2_WIDTH   = SQ_WIDTH + 2;
   localparam int CFG_WIDTH  = 52;
   localparam int CMP_WIDTH  = (D2_WIDTH > CFG_WIDTH) ? D2_WIDTH : CFG_WIDTH;

   // Configuration port
   localparam int DATA_WIDTH    = 64;
   localparam int ADDR_WIDTH    = 5;
   localparam int REG_ADDR_LSB  = 3;
   localparam int REG_SEL_WIDTH = ADDR_WIDTH - REG_ADDR_LSB;

   localparam logic [REG_SEL_WIDTH-1:0] REG_MAX_DIST_SQ      = 2'd0;
   localparam logic [REG_SEL_WIDTH-1:0] REG_MIN_DIST_SQ      = 2'd1;
   localparam logic [REG_SEL_WIDTH-1:0] REG_REPORT_BOTH      = 2'd2;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
   } point_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] max_dist_sq;
      logic [CFG_WIDTH-1:0] min_dist_sq;
      logic                 report_both;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      logic [IDX_WIDTH-1:0] index;
      logic                 match;
   } dist_result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_MARK
   } state_type;

   // Sign-extend the input field, then wrap it to the stored coordinate width
   function automatic logic signed [COORD_WIDTH-1:0] load_coord(
      input logic signed [IN_WIDTH-1:0] raw
   );
      logic signed [31:0] ext;
      ext = 32'(raw);
      return ext[COORD_WIDTH-1:0];
   endfunction

   // Magnitude of b - a; always fits in COORD_WIDTH unsigned bits
   function automatic logic [COORD_WIDTH-1:0] abs_diff(
      input logic signed [COORD_WIDTH-1:0] a,
      input logic signed [COORD_WIDTH-1:0] b
   );
      logic signed [COORD_WIDTH:0] d;
      logic signed [COORD_WIDTH:0] m;
      d = (COORD_WIDTH+1)'(b) - (COORD_WIDTH+1)'(a);
      m = d[COORD_WIDTH] ? -d : d;
      return m[COORD_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- design/apcnl_csr.sv -----
`default_nettype none

module apcnl_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [apcnl_pkg::ADDR_WIDTH-1:0] paddr,
   input  wire logic [apcnl_pkg::DATA_WIDTH-1:0] pwdata,
   output logic      [apcnl_pkg::DATA_WIDTH-1:0] prdata,
   output logic                                 pready,
   output apcnl_pkg::cfg_type                   cfg
);
   import apcnl_pkg::*;

   cfg_type                  cfg_ff;
   cfg_type                  cfg_in;
   logic [REG_SEL_WIDTH-1:0] sel;
   logic                     wr_en;

   assign pready = 1'b1;
   assign sel    = paddr[ADDR_WIDTH-1:REG_ADDR_LSB];
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (sel)
            REG_MAX_DIST_SQ: cfg_in.max_dist_sq = pwdata[CFG_WIDTH-1:0];
            REG_MIN_DIST_SQ: cfg_in.min_dist_sq = pwdata[CFG_WIDTH-1:0];
            REG_REPORT_BOTH: cfg_in.report_both = pwdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         REG_MAX_DIST_SQ: prdata = DATA_WIDTH'(cfg_ff.max_dist_sq);
         REG_MIN_DIST_SQ: prdata = DATA_WIDTH'(cfg_ff.min_dist_sq);
         REG_REPORT_BOTH: prdata = DATA_WIDTH'(cfg_ff.report_both);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- design/apcnl_store.sv -----
`default_nettype none

module apcnl_store (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [apcnl_pkg::IDX_WIDTH-1:0] wr_addr,
   input  wire apcnl_pkg::point_type           wr_data,
   input  wire logic                           rd_en,
   input  wire logic [apcnl_pkg::IDX_WIDTH-1:0] rd_addr,
   output apcnl_pkg::point_type                rd_data
);
   import apcnl_pkg::*;

   point_type mem_ff [MAX_POINTS];
   point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Hold the read data while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/apcnl_dist.sv -----
`default_nettype none

module apcnl_dist (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire logic                           in_valid,
   input  wire logic [apcnl_pkg::IDX_WIDTH-1:0] in_index,
   input  wire apcnl_pkg::point_type           stored,
   input  wire apcnl_pkg::point_type           probe,
   input  wire apcnl_pkg::cfg_type             cfg,
   output apcnl_pkg::dist_result_type          result,
   output logic                                busy
);
   import apcnl_pkg::*;

   // Stage 2: coordinate magnitudes
   logic                   v2_ff;
   logic [IDX_WIDTH-1:0]   idx2_ff;
   logic [COORD_WIDTH-1:0] mag_x_ff, mag_y_ff, mag_z_ff;
   // Stage 3: squares
   logic                   v3_ff;
   logic [IDX_WIDTH-1:0]   idx3_ff;
   logic [SQ_WIDTH-1:0]    sq_x_ff, sq_y_ff, sq_z_ff;
   // Stage 4: squared distance
   logic                   v4_ff;
   logic [IDX_WIDTH-1:0]   idx4_ff;
   logic [D2_WIDTH-1:0]    d2_ff;
   // Stage 5: window test
   logic                   v5_ff;
   logic [IDX_WIDTH-1:0]   idx5_ff;
   logic                   match5_ff;
   logic                   match5_in;

   assign match5_in = (CMP_WIDTH'(d2_ff) >= CMP_WIDTH'(cfg.min_dist_sq)) &&
                      (CMP_WIDTH'(d2_ff) <= CMP_WIDTH'(cfg.max_dist_sq));

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= in_valid;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         idx2_ff   <= in_index;
         mag_x_ff  <= abs_diff(stored.x, probe.x);
         mag_y_ff  <= abs_diff(stored.y, probe.y);
         mag_z_ff  <= abs_diff(stored.z, probe.z);
         idx3_ff   <= idx2_ff;
         sq_x_ff   <= mag_x_ff * mag_x_ff;
         sq_y_ff   <= mag_y_ff * mag_y_ff;
         sq_z_ff   <= mag_z_ff * mag_z_ff;
         idx4_ff   <= idx3_ff;
         d2_ff     <= D2_WIDTH'(sq_x_ff) + D2_WIDTH'(sq_y_ff) + D2_WIDTH'(sq_z_ff);
         idx5_ff   <= idx4_ff;
         match5_ff <= match5_in;
      end
   end

   assign result.valid = v5_ff;
   assign result.index = idx5_ff;
   assign result.match = match5_ff;
   assign busy         = v2_ff || v3_ff || v4_ff || v5_ff;

endmodule

`default_nettype wire

// ----- design/all_pairs_cutoff_neighbor_list.sv -----
// Flow: for n > 0 stored points the scan reads all n, each passes the store read and
//   distance stages, then the end marker follows; an empty or full store skips the scan.
// Throughput: one item at a time, the next taken once the end marker has been loaded;
//   each match in two-order mode and a stalled result transfer stall the scan.
// Reset: clears the point count, the cutoff registers and all control; store contents
//   stay undefined and are never read before they are written.
`default_nettype none

module all_pairs_cutoff_neighbor_list (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input item channel
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [apcnl_pkg::IN_WIDTH-1:0] req_pos_x,
   input  wire logic signed [apcnl_pkg::IN_WIDTH-1:0] req_pos_y,
   input  wire logic signed [apcnl_pkg::IN_WIDTH-1:0] req_pos_z,
   input  wire logic                                 req_first_in_set,
   // result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [apcnl_pkg::OUT_IDX_WIDTH-1:0]       rsp_first_index,
   output logic [apcnl_pkg::OUT_IDX_WIDTH-1:0]       rsp_second_index,
   output logic                                      rsp_is_pair,
   output logic                                      rsp_overflow,
   output logic                                      rsp_last,
   // configuration port
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [apcnl_pkg::ADDR_WIDTH-1:0]      paddr,
   input  wire logic [apcnl_pkg::DATA_WIDTH-1:0]      pwdata,
   output logic      [apcnl_pkg::DATA_WIDTH-1:0]      prdata,
   output logic                                      pready
);
   import apcnl_pkg::*;

   cfg_type cfg;

   // Sequencer state
   state_type              state_ff, state_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;   // points held in the store
   logic [CNT_WIDTH-1:0]   cur_ff, cur_in;       // index the probe point takes
   logic [CNT_WIDTH-1:0]   rd_cnt_ff, rd_cnt_in; // next store entry to read
   logic                   ovf_ff, ovf_in;
   point_type              point_ff, point_in;
   logic                   v1_ff, v1_in;         // tag of the store read data
   logic [IDX_WIDTH-1:0]   idx1_ff, idx1_in;
   logic                   rev_phase_ff, rev_phase_in;

   // Output register
   logic                     out_valid_ff, out_valid_in;
   logic [OUT_IDX_WIDTH-1:0] out_first_ff, out_first_in;
   logic [OUT_IDX_WIDTH-1:0] out_second_ff, out_second_in;
   logic                     out_pair_ff, out_pair_in;
   logic                     out_ovf_ff, out_ovf_in;
   logic                     out_last_ff, out_last_in;

   // Datapath links
   point_type       rd_data;
   dist_result_type dres;
   logic            dist_busy;
   logic            accept;
   logic [CNT_WIDTH-1:0] accept_cur;
   logic            accept_ovf;
   logic            out_free;
   logic            advance;
   logic            issue;
   logic            scan_done;
   logic            mark_fire;
   logic            store_we;
   logic            emit_fwd;
   logic            emit_rev;
   logic            pipe_empty;

   apcnl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   apcnl_store u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (cur_ff[IDX_WIDTH-1:0]),
      .wr_data (point_ff),
      .rd_en   (issue && advance),
      .rd_addr (rd_cnt_ff[IDX_WIDTH-1:0]),
      .rd_data (rd_data)
   );

   apcnl_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (v1_ff),
      .in_index (idx1_ff),
      .stored   (rd_data),
      .probe    (point_ff),
      .cfg      (cfg),
      .result   (dres),
      .busy     (dist_busy)
   );

   // The output slot can take a new result when empty or when its transfer completes now
   assign out_free   = !out_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;
   // first_in_set empties the store ahead of the probe point
   assign accept_cur = req_first_in_set ? '0 : count_ff;
   assign accept_ovf = (accept_cur >= CNT_WIDTH'(MAX_POINTS));
   assign pipe_empty = !v1_ff && !dist_busy;

   // A match leaves the last stage only once its forward pair, and in two-order mode
   // its reversed pair, have gone into the output register; the whole pipe stalls meanwhile.
   assign emit_fwd = dres.valid && dres.match && out_free && !rev_phase_ff;
   assign emit_rev = dres.valid && dres.match && out_free && rev_phase_ff;
   assign advance  = !(dres.valid && dres.match) || emit_rev ||
                     (emit_fwd && !cfg.report_both);

   assign scan_done = (rd_cnt_ff + CNT_WIDTH'(1)) == cur_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (accept_ovf) begin
                  state_in = ST_MARK;
               end else if (accept_cur == '0) begin
                  state_in = ST_DRAIN;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (advance && scan_done) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pipe_empty) begin
               state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      mark_fire = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_SCAN:  issue     = 1'b1;
         ST_DRAIN: ;
         ST_MARK:  mark_fire = out_free;
      endcase
   end

   // Store the probe point, unless the store is full, as the end marker goes out; the pipe is empty by then,
   // so no read can meet this write.
   assign store_we = mark_fire && !ovf_ff;

   // Item registers
   always_comb begin
      count_in     = count_ff;
      cur_in       = cur_ff;
      rd_cnt_in    = rd_cnt_ff;
      ovf_in       = ovf_ff;
      point_in     = point_ff;
      v1_in        = v1_ff;
      idx1_in      = idx1_ff;
      rev_phase_in = rev_phase_ff;

      if (accept) begin
         point_in.x = load_coord(req_pos_x);
         point_in.y = load_coord(req_pos_y);
         point_in.z = load_coord(req_pos_z);
         cur_in     = accept_cur;
         ovf_in     = accept_ovf;
         count_in   = accept_cur;
         rd_cnt_in  = '0;
      end

      if (advance) begin
         v1_in   = issue;
         idx1_in = rd_cnt_ff[IDX_WIDTH-1:0];
         if (issue) begin
            rd_cnt_in = rd_cnt_ff + CNT_WIDTH'(1);
         end
      end

      if (emit_fwd && cfg.report_both) begin
         rev_phase_in = 1'b1;
      end else if (emit_rev) begin
         rev_phase_in = 1'b0;
      end

      if (store_we) begin
         count_in = cur_ff + CNT_WIDTH'(1);
      end
   end

   // Output register: hold while stalled, load a pair or the end marker when free
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_first_in  = out_first_ff;
      out_second_in = out_second_ff;
      out_pair_in   = out_pair_ff;
      out_ovf_in    = out_ovf_ff;
      out_last_in   = out_last_ff;
      if (out_free) begin
         out_valid_in = emit_fwd || emit_rev || mark_fire;
         if (emit_fwd) begin
            out_first_in  = OUT_IDX_WIDTH'(dres.index);
            out_second_in = OUT_IDX_WIDTH'(cur_ff[IDX_WIDTH-1:0]);
            out_pair_in   = 1'b1;
            out_ovf_in    = 1'b0;
            out_last_in   = 1'b0;
         end else if (emit_rev) begin
            out_first_in  = OUT_IDX_WIDTH'(cur_ff[IDX_WIDTH-1:0]);
            out_second_in = OUT_IDX_WIDTH'(dres.index);
            out_pair_in   = 1'b1;
            out_ovf_in    = 1'b0;
            out_last_in   = 1'b0;
         end else if (mark_fire) begin
            out_first_in  = '0;
            out_second_in = '0;
            out_pair_in   = 1'b0;
            out_ovf_in    = ovf_ff;
            out_last_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_cnt_ff    <= '0;
         v1_ff        <= 1'b0;
         rev_phase_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_cnt_ff    <= rd_cnt_in;
         v1_ff        <= v1_in;
         rev_phase_ff <= rev_phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      ovf_ff        <= ovf_in;
      point_ff      <= point_in;
      idx1_ff       <= idx1_in;
      out_first_ff  <= out_first_in;
      out_second_ff <= out_second_in;
      out_pair_ff   <= out_pair_in;
      out_ovf_ff    <= out_ovf_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_first_index  = out_first_ff;
   assign rsp_second_index = out_second_ff;
   assign rsp_is_pair      = out_pair_ff;
   assign rsp_overflow     = out_ovf_ff;
   assign rsp_last         = out_last_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(MAX_POINTS))
      else $error("stored point count exceeds the store depth");

   a_write_idle_pipe: assert property (@(posedge clock) disable iff (reset)
      store_we |-> (pipe_empty && !rev_phase_ff))
      else $error("store write while distance pipeline still busy");

   a_rev_needs_match: assert property (@(posedge clock) disable iff (reset)
      rev_phase_ff |-> (dres.valid && dres.match))
      else $error("reversed pair pending without a matching result");

   a_pair_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_pair) |-> (!rsp_last && !rsp_overflow))
      else $error("pair item flagged as marker");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("new item taken before the current one finished");
`endif

endmodule

`default_nettype wire
